// File: rtl/core/binary_to_decimal_ascii_core_macros.svh
// Assertion macros for the binary to decimal ASCII core.
// Used by the top level only; expects signals clk and rst in scope.
`ifndef BINARY_TO_DECIMAL_ASCII_CORE_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define B2D_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define B2D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/b2d_pkg.sv
// Shared constants and helpers for the binary to decimal ASCII core.
// No dependencies; imported by every module of the core.
package b2d_pkg;

  localparam int VALUE_BITS          = 64;  // width of the input value field
  localparam int VALUE_WIDTH_DEFAULT = 64;  // bits of the value that take part
  localparam int BITS_PER_STEP       = 4;   // binary bits folded into BCD per cycle
  localparam int QUEUE_DEPTH         = 2;   // converted values held between front and back
  localparam int CHAR_W              = 6;
  localparam int COUNT_W             = 5;
  localparam int OUT_TDATA_W         = 16;
  localparam int DIGIT_W             = 4;

  localparam logic [CHAR_W-1:0]  ASCII_ZERO   = 6'd48;
  localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
  localparam logic [DIGIT_W-1:0] DABBLE_ADD   = 4'd3;

  // Decimal digits needed for the largest value of w bits: floor(w*log10(2)) + 1.
  function automatic int digits_for_width(input int w);
    return (w * 30103) / 100000 + 1;
  endfunction

endpackage

// File: rtl/core/b2d_front.sv
// Front end: accepts a value and converts it to packed BCD by shift-and-add-3,
// several bits per cycle, then pushes BCD digits and the digit count. Uses b2d_pkg.
module b2d_front
  import b2d_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [VALUE_BITS-1:0] s_tdata,
  output logic                  q_push,
  input  logic                  q_ready,
  output logic [$clog2(digits_for_width(VALUE_WIDTH)+1)+4*digits_for_width(VALUE_WIDTH)-1:0]
                                q_data
);

  localparam int DIGITS = digits_for_width(VALUE_WIDTH);
  localparam int BCD_W  = DIGIT_W * DIGITS;
  localparam int CNT_W  = $clog2(DIGITS + 1);
  localparam int STEPS  = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int PAD_W  = STEPS * BITS_PER_STEP;
  localparam int STEP_W = $clog2(STEPS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_PUSH
  } state_t;

  state_t             state;
  logic [PAD_W-1:0]   shreg;
  logic [BCD_W-1:0]   bcd;
  logic [STEP_W-1:0]  step;
  logic [PAD_W-1:0]   shreg_next;
  logic [BCD_W-1:0]   bcd_next;
  logic [CNT_W-1:0]   count;

  assign s_tready = (state == ST_IDLE);
  assign q_push   = (state == ST_PUSH);
  assign q_data   = {count, bcd};

  // Fold BITS_PER_STEP bits into the BCD register: adjust digits, then shift
  always_comb begin
    bcd_next   = bcd;
    shreg_next = shreg;
    for (int b = 0; b < BITS_PER_STEP; b++) begin
      for (int d = 0; d < DIGITS; d++) begin
        if (bcd_next[d*DIGIT_W +: DIGIT_W] >= DABBLE_LIMIT) begin
          bcd_next[d*DIGIT_W +: DIGIT_W] = bcd_next[d*DIGIT_W +: DIGIT_W] + DABBLE_ADD;
        end
      end
      {bcd_next, shreg_next} = {bcd_next[BCD_W-2:0], shreg_next, 1'b0};
    end
  end

  // Count digits up to the highest nonzero one; zero still has one digit
  always_comb begin
    count = CNT_W'(1);
    for (int d = 1; d < DIGITS; d++) begin
      if (bcd[d*DIGIT_W +: DIGIT_W] != '0) begin
        count = CNT_W'(d + 1);
      end
    end
  end

  // Sequence accept, conversion steps and hand-off to the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            shreg <= PAD_W'(s_tdata[VALUE_WIDTH-1:0]);
            bcd   <= '0;
            step  <= '0;
            state <= ST_CONVERT;
          end
        end
        ST_CONVERT: begin
          shreg <= shreg_next;
          bcd   <= bcd_next;
          step  <= step + STEP_W'(1);
          if (step == STEP_W'(STEPS - 1)) begin
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (q_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/b2d_queue.sv
// Short register queue between the converter and the digit emitter.
// Uses b2d_pkg for the default depth.
module b2d_queue
  import b2d_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int FILL_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]  entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (fill != FILL_W'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // Store payload at the write pointer
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + FILL_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

endmodule

// File: rtl/core/b2d_back.sv
// Back end: takes BCD digits and count from the queue and emits one ASCII digit per
// cycle if unstalled, most significant first, via an output register. Uses b2d_pkg.
module b2d_back
  import b2d_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  output logic                   q_pop,
  input  logic [$clog2(digits_for_width(VALUE_WIDTH)+1)+4*digits_for_width(VALUE_WIDTH)-1:0]
                                 q_data,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tlast
);

  localparam int DIGITS = digits_for_width(VALUE_WIDTH);
  localparam int BCD_W  = DIGIT_W * DIGITS;
  localparam int CNT_W  = $clog2(DIGITS + 1);
  localparam int IDX_W  = $clog2(DIGITS);

  logic                busy;
  logic [BCD_W-1:0]    bcd;
  logic [CNT_W-1:0]    count;
  logic [IDX_W-1:0]    idx;
  logic                advance;
  logic [DIGIT_W-1:0]  cur_digit;
  logic [CHAR_W-1:0]   out_char;
  logic [COUNT_W-1:0]  out_count;

  assign advance   = !m_tvalid || m_tready;
  assign q_pop     = !busy && q_valid;
  assign cur_digit = bcd[idx*DIGIT_W +: DIGIT_W];
  assign m_tdata   = {{(OUT_TDATA_W - COUNT_W - CHAR_W){1'b0}}, out_count, out_char};

  // Load a converted value, then walk its digits down to the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (advance) begin
        m_tvalid <= busy;
      end
      if (advance && busy) begin
        out_char  <= ASCII_ZERO + CHAR_W'(cur_digit);
        out_count <= COUNT_W'(count);
        m_tlast   <= (idx == '0);
        if (idx == '0) begin
          busy <= 1'b0;
        end else begin
          idx <= idx - IDX_W'(1);
        end
      end
      if (q_pop) begin
        busy  <= 1'b1;
        bcd   <= q_data[BCD_W-1:0];
        count <= q_data[BCD_W +: CNT_W];
        idx   <= IDX_W'(q_data[BCD_W +: CNT_W] - CNT_W'(1));
      end
    end
  end

endmodule

// File: rtl/core/binary_to_decimal_ascii_core.sv
// Binary to decimal ASCII converter, top level. The converter folds 4 bits a cycle;
// a new value is accepted only once the previous one is converted and pushed to the
// queue. The emitter's time per value grows with its digit count, so long values set
// the sustained rate. Synchronous active-high reset empties the queue and output
// register; no clearing pass. Uses b2d_pkg, b2d_front/queue/back.
`include "binary_to_decimal_ascii_core_macros.svh"

module binary_to_decimal_ascii_core
  import b2d_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [VALUE_BITS-1:0]  s_tdata,   // [63:0] value
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [5:0] digit_char, [10:6] digit_count, rest 0
  output logic                   m_tlast    // last_digit
);

  localparam int DIGITS  = digits_for_width(VALUE_WIDTH);
  localparam int ENTRY_W = $clog2(DIGITS + 1) + DIGIT_W * DIGITS;

  logic               q_push;
  logic               q_ready;
  logic [ENTRY_W-1:0] q_wdata;
  logic               q_valid;
  logic               q_pop;
  logic [ENTRY_W-1:0] q_rdata;

  b2d_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .q_push  (q_push),
    .q_ready (q_ready),
    .q_data  (q_wdata)
  );

  b2d_queue #(
    .DEPTH(QUEUE_DEPTH),
    .WIDTH(ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_ready(q_ready),
    .push_data (q_wdata),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_data  (q_rdata)
  );

  b2d_back #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_data  (q_rdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  // Digits of one run are offered back to back once the first is out
  `B2D_ASSERT_NEXT(a_run_unbroken, m_tvalid && m_tready && !m_tlast, m_tvalid, "digit run broken")
  // Every emitted character is an ASCII decimal digit
  `B2D_ASSERT_SAME(a_char_range, m_tvalid, (m_tdata[5:0] >= ASCII_ZERO) && (m_tdata[5:0] <= (ASCII_ZERO + 6'd9)), "non-digit character")
  // Digit count stays within what the value width allows
  `B2D_ASSERT_SAME(a_count_range, m_tvalid, (m_tdata[10:6] != 5'd0) && (m_tdata[10:6] <= 5'(DIGITS)), "digit count out of range")

endmodule
